FILE: src/tpb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpb_pkg
// shared types and constants of the tile pixel blitter
// ----------------------------------------------------------------------------
package tpb_pkg;

    // graphics sheet
    localparam int GFX_BYTES   = 65536;
    localparam int GFX_ADDR_W  = $clog2(GFX_BYTES);
    localparam int SRC_W       = 16;              // tile source address bits
    localparam int SRC_CMP_W   = SRC_W + 1;       // room to hold the sheet size itself

    // canvas arithmetic
    localparam int CFG_W       = 11;              // canvas width and height
    localparam int IDX_W       = 20;              // destination index on the bus
    localparam int DEST_W      = 21;              // unwrapped destination index
    localparam int LIMIT_W     = 2 * CFG_W;       // width times height

    // tile geometry
    localparam int PIX_CNT_W   = 6;               // 64 pixels per tile
    localparam logic [PIX_CNT_W-1:0] LAST_PIXEL = 6'd63;
    localparam logic [2:0]     LAST_COLUMN = 3'd7;

    // bus widths
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 32;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    // reset values of the canvas registers
    localparam logic [CFG_W-1:0] CANVAS_WIDTH_RST  = 11'd512;
    localparam logic [CFG_W-1:0] CANVAS_HEIGHT_RST = 11'd512;

    // register word index (paddr bit 2)
    localparam logic REG_CANVAS_WIDTH  = 1'b0;
    localparam logic REG_CANVAS_HEIGHT = 1'b1;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_DRAW = 1'b1
    } op_t;

    typedef enum logic
    {
        ST_IDLE = 1'b0,
        ST_DRAW = 1'b1
    } state_t;

    // pixel metadata that travels beside the sheet read, with the draw
    // settings it needs so a following draw can start while it drains
    typedef struct packed
    {
        logic [DEST_W-1:0] dest;
        logic              src_ok;
        logic              dest_ok;
        logic [7:0]        bank;
        logic              prio;
        logic              last;
    } pix_stage_t;

endpackage : tpb_pkg
`default_nettype wire

FILE: src/tile_pixel_blitter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tile_pixel_blitter
// 8x8 tile blitter with flip and 16-color palette banks over a 64 KiB sheet
// ----------------------------------------------------------------------------
// usage
//   s_* channel takes one transaction per item; s_tuser is the op.
//   a load writes one byte of the 128-byte-wide graphics sheet in the
//   acceptance cycle and gives no result.
//   a draw gives 64 pixel-write transactions on m_*, raster order, m_tlast
//   on the 64th.
//   canvas width and height sit on the apb port (byte address 0 and 4);
//   write them only while no draw is in flight.
// sequence
//   a draw holds s_tready low while it issues one sheet read per pixel on
//   the single-port sheet memory. an accepted draw is registered in the
//   control state and draw parameters, then passes the read stage and the
//   output register before its first pixel appears on m_*.
//   s_tready returns once the last read is issued, while the tail of the
//   tile still drains; the next item may then be taken.
// reset
//   rst_n clears control state and sets the canvas to 512 x 512. the sheet
//   is not cleared: a byte must be loaded before a draw reads it.
// stall
//   when m_tready is low a pending output holds, the read stage holds once
//   it is full, and sheet reads stop then; no pixel is dropped or repeated.
// ----------------------------------------------------------------------------
module tile_pixel_blitter
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    // input item
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [15:0] gfx_address, [23:16] gfx_byte, [33:24] tile_id, [36:34] palette,
    // [37] priority_bit, [38] hflip, [39] vflip, [59:40] dest_offset, [63:60] zero
    input  wire logic [tpb_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] op
    input  wire logic                          s_tuser,

    // pixel writes
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [19:0] pixel index, [27:20] color, [28] pixel_priority, [29] write_enable,
    // [31:30] zero
    output logic [tpb_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tlast,

    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tpb_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [tpb_pkg::PDATA_W-1:0]   pwdata,
    output logic [tpb_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    // ------------------------------------------------------------------
    // input fields
    // ------------------------------------------------------------------
    tpb_pkg::op_t       in_op;
    logic [15:0]        in_gfx_address;
    logic [7:0]         in_gfx_byte;
    logic [9:0]         in_tile_id;
    logic [2:0]         in_palette;
    logic               in_priority;
    logic               in_hflip;
    logic               in_vflip;
    logic [tpb_pkg::IDX_W-1:0] in_dest_offset;

    assign in_op          = tpb_pkg::op_t'(s_tuser);
    assign in_gfx_address = s_tdata[15:0];
    assign in_gfx_byte    = s_tdata[23:16];
    assign in_tile_id     = s_tdata[33:24];
    assign in_palette     = s_tdata[36:34];
    assign in_priority    = s_tdata[37];
    assign in_hflip       = s_tdata[38];
    assign in_vflip       = s_tdata[39];
    assign in_dest_offset = s_tdata[59:40];

    logic in_accept;
    assign in_accept = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [tpb_pkg::CFG_W-1:0] canvas_width_reg;
    logic [tpb_pkg::CFG_W-1:0] canvas_height_reg;
    logic                      cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg  <= tpb_pkg::CANVAS_WIDTH_RST;
            canvas_height_reg <= tpb_pkg::CANVAS_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                tpb_pkg::REG_CANVAS_WIDTH:  canvas_width_reg  <= pwdata[tpb_pkg::CFG_W-1:0];
                tpb_pkg::REG_CANVAS_HEIGHT: canvas_height_reg <= pwdata[tpb_pkg::CFG_W-1:0];
                default:                    ;
            endcase
        end
    end

    // byte offset ignored, word index picks the register
    always_comb
    begin
        unique case (paddr[2])
            tpb_pkg::REG_CANVAS_WIDTH:
                prdata = tpb_pkg::PDATA_W'(canvas_width_reg);
            tpb_pkg::REG_CANVAS_HEIGHT:
                prdata = tpb_pkg::PDATA_W'(canvas_height_reg);
            default:
                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // control state machine
    // ------------------------------------------------------------------
    tpb_pkg::state_t state_reg;
    tpb_pkg::state_t state_next;

    logic [tpb_pkg::PIX_CNT_W-1:0] pix_cnt_reg;
    logic                          p1_valid_reg;
    logic                          out_load;     // output register free or draining
    logic                          p1_free;
    logic                          issue_read;
    logic                          mem_we;

    assign out_load = !m_tvalid || m_tready;
    assign p1_free  = !p1_valid_reg || out_load;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tpb_pkg::ST_IDLE:
            begin
                if (s_tvalid && in_op == tpb_pkg::OP_DRAW)
                    state_next = tpb_pkg::ST_DRAW;
            end
            tpb_pkg::ST_DRAW:
            begin
                if (issue_read && pix_cnt_reg == tpb_pkg::LAST_PIXEL)
                    state_next = tpb_pkg::ST_IDLE;
            end
            default:
                state_next = tpb_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        issue_read = 1'b0;
        unique case (state_reg)
            tpb_pkg::ST_IDLE: s_tready   = 1'b1;
            tpb_pkg::ST_DRAW: issue_read = p1_free;
            default:          ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tpb_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ------------------------------------------------------------------
    // draw parameters, latched when the draw transaction is taken
    // ------------------------------------------------------------------
    logic [5:0]                   trow_reg;
    logic [3:0]                   tile_col_reg;
    logic [7:0]                   bank_reg;
    logic                         prio_reg;
    logic                         hflip_reg;
    logic                         vflip_reg;
    logic [tpb_pkg::LIMIT_W-1:0]  limit_reg;
    logic [tpb_pkg::DEST_W-1:0]   row_dest_reg;
    logic [tpb_pkg::DEST_W-1:0]   row_dest_next;
    logic [tpb_pkg::PIX_CNT_W-1:0] pix_cnt_next;
    logic [7:0]                   bank_next;
    logic                         draw_start;

    assign draw_start = in_accept && in_op == tpb_pkg::OP_DRAW;

    // palettes 2..7 pick bank 0..5, palettes 0 and 1 add nothing
    always_comb
    begin
        if (in_palette >= 3'd2)
            bank_next = {1'b0, in_palette - 3'd2, 4'b0000};
        else
            bank_next = '0;
    end

    logic [2:0] pix_x;
    logic [2:0] pix_y;
    logic [2:0] src_x;
    logic [2:0] src_y;

    assign pix_x = pix_cnt_reg[2:0];
    assign pix_y = pix_cnt_reg[5:3];
    assign src_x = hflip_reg ? ~pix_x : pix_x;
    assign src_y = vflip_reg ? ~pix_y : pix_y;

    always_comb
    begin
        pix_cnt_next  = pix_cnt_reg;
        row_dest_next = row_dest_reg;
        if (draw_start)
        begin
            pix_cnt_next  = '0;
            row_dest_next = tpb_pkg::DEST_W'(in_dest_offset);
        end
        else if (issue_read)
        begin
            pix_cnt_next = pix_cnt_reg + tpb_pkg::PIX_CNT_W'(1);
            // step one canvas row after the last column
            if (pix_x == tpb_pkg::LAST_COLUMN)
                row_dest_next = row_dest_reg + tpb_pkg::DEST_W'(canvas_width_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pix_cnt_reg <= '0;
        else
            pix_cnt_reg <= pix_cnt_next;
    end

    always_ff @(posedge clk)
    begin
        row_dest_reg <= row_dest_next;
        if (draw_start)
        begin
            trow_reg     <= in_tile_id[9:4];
            tile_col_reg <= in_tile_id[3:0];
            bank_reg     <= bank_next;
            prio_reg     <= in_priority;
            hflip_reg    <= in_hflip;
            vflip_reg    <= in_vflip;
            limit_reg    <= tpb_pkg::LIMIT_W'(canvas_width_reg)
                          * tpb_pkg::LIMIT_W'(canvas_height_reg);
        end
    end

    // ------------------------------------------------------------------
    // graphics sheet memory
    // ------------------------------------------------------------------
    // sheet byte = trow*1024 + src_y*128 + tile_col*8 + src_x
    logic [tpb_pkg::SRC_W-1:0]      src_addr;
    logic                           src_ok;
    logic                           load_ok;
    logic [tpb_pkg::GFX_ADDR_W-1:0] rd_addr;
    logic [tpb_pkg::GFX_ADDR_W-1:0] wr_addr;
    logic [7:0]                     rd_data_reg;

    assign src_addr = {trow_reg, src_y, tile_col_reg, src_x};
    assign src_ok   = tpb_pkg::SRC_CMP_W'(src_addr) < tpb_pkg::SRC_CMP_W'(tpb_pkg::GFX_BYTES);
    assign load_ok  = tpb_pkg::SRC_CMP_W'(in_gfx_address)
                    < tpb_pkg::SRC_CMP_W'(tpb_pkg::GFX_BYTES);
    assign rd_addr  = src_addr[tpb_pkg::GFX_ADDR_W-1:0];
    assign wr_addr  = in_gfx_address[tpb_pkg::GFX_ADDR_W-1:0];
    assign mem_we   = in_accept && in_op == tpb_pkg::OP_LOAD && load_ok;

    logic [7:0] gfx_mem [tpb_pkg::GFX_BYTES];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            gfx_mem[wr_addr] <= in_gfx_byte;
        if (issue_read)
            rd_data_reg <= gfx_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // read stage: metadata beside the registered sheet byte
    // ------------------------------------------------------------------
    tpb_pkg::pix_stage_t p1_reg;
    tpb_pkg::pix_stage_t p1_next;
    logic                p1_valid_next;

    always_comb
    begin
        p1_next.dest    = row_dest_reg + tpb_pkg::DEST_W'(pix_x);
        p1_next.src_ok  = src_ok;
        // bounds use the full unwrapped index
        p1_next.dest_ok = tpb_pkg::LIMIT_W'(p1_next.dest) < limit_reg;
        p1_next.bank    = bank_reg;
        p1_next.prio    = prio_reg;
        p1_next.last    = pix_cnt_reg == tpb_pkg::LAST_PIXEL;

        if (issue_read)
            p1_valid_next = 1'b1;
        else if (out_load)
            p1_valid_next = 1'b0;
        else
            p1_valid_next = p1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else
            p1_valid_reg <= p1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (issue_read)
            p1_reg <= p1_next;
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic                        m_tvalid_reg;
    logic                        m_tvalid_next;
    logic [tpb_pkg::IDX_W-1:0]   pix_index_reg;
    logic [7:0]                  color_reg;
    logic                        prio_out_reg;
    logic                        we_reg;
    logic                        last_reg;
    logic                        we_next;
    logic                        out_take;

    assign out_take      = out_load && p1_valid_reg;
    assign m_tvalid_next = out_load ? p1_valid_reg : m_tvalid_reg;

    // nonzero pixel, source on the sheet, destination on the canvas
    assign we_next = p1_reg.src_ok && rd_data_reg != 8'd0 && p1_reg.dest_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            pix_index_reg <= p1_reg.dest[tpb_pkg::IDX_W-1:0];
            color_reg     <= we_next ? rd_data_reg + p1_reg.bank : 8'd0;
            prio_out_reg  <= we_next && p1_reg.prio;
            we_reg        <= we_next;
            last_reg      <= p1_reg.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {2'b00, we_reg, prio_out_reg, color_reg, pix_index_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a draw closes the input until its reads are issued
    assert property (@(posedge clk) disable iff (!rst_n)
        draw_start |=> !s_tready)
    else $error("input accepted right after a draw transaction");

    // the 64th read ends the draw
    assert property (@(posedge clk) disable iff (!rst_n)
        issue_read && pix_cnt_reg == tpb_pkg::LAST_PIXEL |=> state_reg == tpb_pkg::ST_IDLE)
    else $error("draw did not end after the last pixel read");

    // the sheet port never sees a load and a read together
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !issue_read)
    else $error("sheet write and read in the same cycle");

    // a stalled output holds the read stage
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready && p1_valid_reg |=> p1_valid_reg && $stable(p1_reg))
    else $error("read stage moved under an output stall");

endmodule : tile_pixel_blitter
`default_nettype wire
